FILE: sv/apd_pkg.sv
// ----------------------------------------------------------------------------
// apd_pkg
// Shared constants and types for the two-axis ankle proportional drive.
// ----------------------------------------------------------------------------
package apd_pkg;

   localparam int CMD_FRAC_BITS = 14;
   localparam int CMD_SCALE     = 1 << CMD_FRAC_BITS;

   localparam int FIELD_W = 16;
   localparam int GAIN_W  = 20;
   localparam int CMD_W   = FIELD_W + 1;
   localparam int NUM_W   = FIELD_W + CMD_FRAC_BITS + 2;
   localparam int PROD_W  = NUM_W + GAIN_W + 1;
   localparam int MUL_K_W = 4;
   localparam int SCL_W   = PROD_W + MUL_K_W;
   localparam int MAG_W   = 17;
   localparam int LIM_W   = 15;

   localparam int LANE_STAGES = 6;

   localparam int SH_ONE = CMD_FRAC_BITS + 8;

   localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};
   localparam logic [15:0]      RECIP5    = 16'd52429;
   localparam int               RECIP5_SH = 18;

   localparam logic CSR_DRIVE_MODE = 1'b0;
   localparam logic CSR_GAIN       = 1'b1;

   localparam logic              MODE_RESET = 1'b1;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(153600);

   localparam logic signed [CMD_W-1:0] CMD_MAX = CMD_W'(CMD_SCALE);
   localparam logic signed [CMD_W-1:0] CMD_MIN = -CMD_W'(CMD_SCALE);

   localparam logic signed [NUM_W-1:0] REST_NUM  = NUM_W'(1000 * CMD_SCALE);
   localparam logic signed [NUM_W-1:0] TGT_MIN   = NUM_W'(250 * CMD_SCALE);
   localparam logic signed [NUM_W-1:0] TGT_MAX   = NUM_W'(2400 * CMD_SCALE);
   localparam logic signed [NUM_W-1:0] FLEX_POS  = NUM_W'(750);
   localparam logic signed [NUM_W-1:0] FLEX_NEG  = NUM_W'(1400);
   localparam logic signed [NUM_W-1:0] TILT_GAIN = NUM_W'(285);

   localparam logic [LIM_W-1:0] LIM_VOLT   = LIM_W'(11500);
   localparam logic [LIM_W-1:0] LIM_CUR    = LIM_W'(32600);
   localparam logic [LIM_W-1:0] DEAD1_VOLT = LIM_W'(1525);
   localparam logic [LIM_W-1:0] DEAD2_VOLT = LIM_W'(1675);
   localparam logic [LIM_W-1:0] DEAD1_CUR  = LIM_W'(7500);
   localparam logic [LIM_W-1:0] DEAD2_CUR  = LIM_W'(12000);

   localparam logic [MUL_K_W-1:0] K_ONE  = MUL_K_W'(1);
   localparam logic [MUL_K_W-1:0] K_VOLT = MUL_K_W'(11);
   localparam logic [MUL_K_W-1:0] K_CUR  = MUL_K_W'(5);

   typedef struct packed {
      logic [MUL_K_W-1:0] mul_k;
      logic               half;
      logic               fifth;
      logic [LIM_W-1:0]   dead;
      logic [LIM_W-1:0]   lim;
   } lane_ctl_type;

endpackage

FILE: sv/apd_lane.sv
// ----------------------------------------------------------------------------
// apd_lane
// One motor: target clamp, error times gain, mode scaling, truncation,
// deadband and saturation over six register stages.
// ----------------------------------------------------------------------------
module apd_lane
   import apd_pkg::*;
(
   input  logic                       clock,
   input  logic [LANE_STAGES-1:0]     stage_en,
   input  lane_ctl_type               ctl,
   input  logic                       tilt_neg,
   input  logic signed [NUM_W-1:0]    base,
   input  logic signed [NUM_W-1:0]    tilt,
   input  logic signed [FIELD_W-1:0]  angle,
   input  logic [GAIN_W-1:0]          gain,
   output logic signed [FIELD_W-1:0]  drive
);

   logic signed [NUM_W-1:0]   sum_num;
   logic signed [NUM_W-1:0]   target;
   logic signed [NUM_W-1:0]   angle_num;
   logic signed [NUM_W-1:0]   diff_in, diff_ff;
   logic signed [GAIN_W:0]    gain_s;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [MUL_K_W:0]   k_s;
   logic signed [SCL_W-1:0]   scaled_in, scaled_ff;
   logic [SCL_W-1:0]          mag_full;
   logic [SCL_W-1:0]          quot;
   logic [MAG_W-1:0]          mag_in, mag_ff;
   logic                      neg4_ff, neg5_ff;
   logic [MAG_W+15:0]         prod5;
   logic [MAG_W-1:0]          q_in, q_ff;
   logic [LIM_W-1:0]          shp;
   logic signed [FIELD_W-1:0] drive_in, drive_ff;

   // target and error
   always_comb begin
      sum_num   = tilt_neg ? base - tilt : base + tilt;
      target    = sum_num;
      if (sum_num < TGT_MIN) begin
         target = TGT_MIN;
      end else if (sum_num > TGT_MAX) begin
         target = TGT_MAX;
      end
      angle_num = NUM_W'(angle) <<< CMD_FRAC_BITS;
      diff_in   = angle_num - target;
   end

   assign gain_s  = $signed({1'b0, gain});
   assign prod_in = diff_ff * gain_s;

   assign k_s       = $signed({1'b0, ctl.mul_k});
   assign scaled_in = prod_ff * k_s;

   // truncate toward zero on the magnitude
   always_comb begin
      mag_full = scaled_ff[SCL_W-1] ? SCL_W'(-scaled_ff) : SCL_W'(scaled_ff);
      quot     = mag_full >> SH_ONE;
      if (ctl.half) begin
         quot = quot >> 1;
      end
      if (|quot[SCL_W-1:MAG_W]) begin
         mag_in = MAG_CAP;
      end else begin
         mag_in = quot[MAG_W-1:0];
      end
   end

   // divide by five, exact below 2^18
   always_comb begin
      prod5 = {16'd0, mag_ff} * {{MAG_W{1'b0}}, RECIP5};
      q_in  = ctl.fifth ? MAG_W'(prod5 >> RECIP5_SH) : mag_ff;
   end

   always_comb begin
      if (q_ff > MAG_W'(ctl.lim)) begin
         shp = ctl.lim;
      end else if (q_ff < MAG_W'(ctl.dead)) begin
         shp = '0;
      end else begin
         shp = q_ff[LIM_W-1:0];
      end
      drive_in = neg5_ff ? -$signed({1'b0, shp}) : $signed({1'b0, shp});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         diff_ff <= diff_in;
      end
      if (stage_en[1]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[2]) begin
         scaled_ff <= scaled_in;
      end
      if (stage_en[3]) begin
         mag_ff  <= mag_in;
         neg4_ff <= scaled_ff[SCL_W-1];
      end
      if (stage_en[4]) begin
         q_ff    <= q_in;
         neg5_ff <= neg4_ff;
      end
      if (stage_en[5]) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

endmodule

FILE: sv/apd_merge.sv
// ----------------------------------------------------------------------------
// apd_merge
// Joins the two lane drives and the mode flag into the result register.
// ----------------------------------------------------------------------------
module apd_merge
   import apd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [FIELD_W-1:0]  drive_one,
   input  logic signed [FIELD_W-1:0]  drive_two,
   input  logic                       mode,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [2*FIELD_W-1:0]       rsp_tdata,  // drive_one, drive_two
   output logic                       rsp_tuser   // drive_is_current
);

   logic                 valid_in, valid_ff;
   logic [2*FIELD_W-1:0] data_ff;
   logic                 user_ff;

   assign in_ready = !valid_ff || rsp_tready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= {drive_two, drive_one};
         user_ff <= mode;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

FILE: sv/two_axis_ankle_p_drive.sv
// ----------------------------------------------------------------------------
// two_axis_ankle_p_drive
// Pipeline: front stage, six lane stages, then the result register.
// Throughput: one item per cycle while the receiver takes results; the two motor lanes run side by side.
// Reset (synchronous): pipeline emptied, drive_mode = 1, gain = 153600.
// ----------------------------------------------------------------------------
module two_axis_ankle_p_drive
   import apd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [4*FIELD_W-1:0]  req_tdata,  // flex_command, tilt_command, angle_one, angle_two
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*FIELD_W-1:0]  rsp_tdata,  // drive_one, drive_two
   output logic                  rsp_tuser,  // drive_is_current
   input  logic                  csr_wen,
   input  logic                  csr_addr,
   input  logic [GAIN_W-1:0]     csr_wdata
);

   logic                      mode_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [LANE_STAGES:0]      v_in, v_ff, en;
   logic                      merge_ready;
   logic signed [CMD_W-1:0]   p_cmd, t_cmd;
   logic signed [NUM_W-1:0]   base_in, base_ff;
   logic signed [NUM_W-1:0]   tilt_in, tilt_ff;
   logic signed [FIELD_W-1:0] a1_ff, a2_ff;
   lane_ctl_type              ctl_one, ctl_two;
   logic signed [FIELD_W-1:0] drive_one, drive_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_DRIVE_MODE: mode_ff <= csr_wdata[0];
            CSR_GAIN:       gain_ff <= csr_wdata;
            default:        mode_ff <= mode_ff;
         endcase
      end
   end

   // stage advance chain
   always_comb begin
      en[LANE_STAGES] = !v_ff[LANE_STAGES] || merge_ready;
      for (int i = LANE_STAGES - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int i = 1; i <= LANE_STAGES; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // command clamp, rest offset and tilt mix
   always_comb begin
      p_cmd = CMD_W'($signed(req_tdata[FIELD_W-1:0]));
      t_cmd = CMD_W'($signed(req_tdata[2*FIELD_W-1:FIELD_W]));
      if (p_cmd > CMD_MAX) begin
         p_cmd = CMD_MAX;
      end else if (p_cmd < CMD_MIN) begin
         p_cmd = CMD_MIN;
      end
      if (t_cmd > CMD_MAX) begin
         t_cmd = CMD_MAX;
      end else if (t_cmd < CMD_MIN) begin
         t_cmd = CMD_MIN;
      end
      base_in = REST_NUM - NUM_W'(p_cmd) * (p_cmd[CMD_W-1] ? FLEX_NEG : FLEX_POS);
      tilt_in = NUM_W'(t_cmd) * TILT_GAIN;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         base_ff <= base_in;
         tilt_ff <= tilt_in;
         a1_ff   <= $signed(req_tdata[3*FIELD_W-1:2*FIELD_W]);
         a2_ff   <= $signed(req_tdata[4*FIELD_W-1:3*FIELD_W]);
      end
   end

   always_comb begin
      ctl_one.mul_k = K_ONE;
      ctl_one.half  = 1'b0;
      ctl_one.fifth = 1'b0;
      ctl_one.dead  = mode_ff ? DEAD1_CUR : DEAD1_VOLT;
      ctl_one.lim   = mode_ff ? LIM_CUR : LIM_VOLT;
      ctl_two.mul_k = mode_ff ? K_CUR : K_VOLT;
      ctl_two.half  = 1'b1;
      ctl_two.fifth = !mode_ff;
      ctl_two.dead  = mode_ff ? DEAD2_CUR : DEAD2_VOLT;
      ctl_two.lim   = mode_ff ? LIM_CUR : LIM_VOLT;
   end

   apd_lane u_lane_one (
      .clock    (clock),
      .stage_en (en[LANE_STAGES:1]),
      .ctl      (ctl_one),
      .tilt_neg (1'b0),
      .base     (base_ff),
      .tilt     (tilt_ff),
      .angle    (a1_ff),
      .gain     (gain_ff),
      .drive    (drive_one)
   );

   apd_lane u_lane_two (
      .clock    (clock),
      .stage_en (en[LANE_STAGES:1]),
      .ctl      (ctl_two),
      .tilt_neg (1'b1),
      .base     (base_ff),
      .tilt     (tilt_ff),
      .angle    (a2_ff),
      .gain     (gain_ff),
      .drive    (drive_two)
   );

   apd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v_ff[LANE_STAGES]),
      .in_ready   (merge_ready),
      .drive_one  (drive_one),
      .drive_two  (drive_two),
      .mode       (mode_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   a_empty_out_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with result register empty");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted transfer lost at front stage");

   a_volt_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ($signed(rsp_tdata[FIELD_W-1:0]) <= 11500 &&
          $signed(rsp_tdata[FIELD_W-1:0]) >= -11500 &&
          $signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) <= 11500 &&
          $signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) >= -11500))
      else $error("voltage drive beyond limit");

   a_cur_deadband: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         ($signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) == 0 ||
          $signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) >= 12000 ||
          $signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) <= -12000))
      else $error("motor two current drive inside deadband");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-axis ankle proportional drive. Command
// clamps, target limits, deadband and saturation edges are driven first,
// then random commands under many drive mode and gain settings. Each
// request transfer is run through a local copy of the control law and the
// drives that come back are compared in order. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module tb;
   import apd_pkg::*;

   // from the lowest bit up: flex, tilt, angle_one, angle_two
   typedef struct packed {
      logic signed [FIELD_W-1:0] angle_two;
      logic signed [FIELD_W-1:0] angle_one;
      logic signed [FIELD_W-1:0] tilt;
      logic signed [FIELD_W-1:0] flex;
   } ankle_cmd_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] drive_one;
      logic signed [FIELD_W-1:0] drive_two;
      logic                      is_current;
   } drive_set_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   ankle_cmd_type        req_tdata  = '0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_wen    = 1'b0;
   logic                 csr_addr   = CSR_DRIVE_MODE;
   logic [GAIN_W-1:0]    csr_wdata  = '0;
   wire                  req_tready;
   wire                  rsp_tvalid;
   wire [2*FIELD_W-1:0]  rsp_tdata;   // drive_one, drive_two
   wire                  rsp_tuser;   // drive_is_current

   // register copies as the block holds them, and as the stimulus assumes
   logic              mode_now  = MODE_RESET;
   logic [GAIN_W-1:0] gain_now  = GAIN_RESET;
   logic              stim_mode = MODE_RESET;
   logic [GAIN_W-1:0] stim_gain = GAIN_RESET;

   drive_set_type pending_drives[$];
   int         fault_count   = 0;
   int         requests_sent = 0;
   int         drives_seen   = 0;
   int         settings_used = 1;
   int         cycle_count   = 0;
   int         burst_left    = 0;
   int         rx_hold       = 0;
   bit         tx_idle_on    = 1'b0;
   bit         rx_idle_on    = 1'b0;

   two_axis_ankle_p_drive uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_ll(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint shape_drive(longint v, longint dead, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      if (v < dead && v > -dead) return 0;
      return v;
   endfunction

   // motor target in units of 1/CMD_SCALE centidegrees
   function automatic longint target_num(ankle_cmd_type c, bit second);
      longint s, p, t, base, mix;
      s = CMD_SCALE;
      p = clamp_ll(longint'(c.flex), -s, s);
      t = clamp_ll(longint'(c.tilt), -s, s);
      base = (p >= 0) ? 1000 * s - 750 * p : 1000 * s - 1400 * p;
      mix = 285 * t;
      return clamp_ll(second ? base - mix : base + mix, 250 * s, 2400 * s);
   endfunction

   function automatic drive_set_type predict_drives(ankle_cmd_type c, logic cur,
                                                    logic [GAIN_W-1:0] g);
      longint s, gl, n1, n2, lim;
      drive_set_type r;
      s = CMD_SCALE;
      gl = g;
      lim = cur ? 32600 : 11500;
      n1 = (longint'(c.angle_one) * s - target_num(c, 1'b0)) * gl;
      n2 = (longint'(c.angle_two) * s - target_num(c, 1'b1)) * gl * (cur ? 5 : 11);
      r.drive_one = shape_drive(n1 / (s * 256), cur ? 7500 : 1525, lim);
      r.drive_two = shape_drive(n2 / (s * 256 * (cur ? 2 : 10)), cur ? 12000 : 1675, lim);
      r.is_current = cur;
      return r;
   endfunction

   function automatic longint rand_pm(longint span);
      return longint'($urandom_range(0, int'(2 * span))) - span;
   endfunction

   function automatic logic signed [FIELD_W-1:0] corner_cmd();
      int corners[10] = '{-32768, -16385, -16384, -16383, -1, 0, 16383, 16384, 16385, 32767};
      return corners[$urandom_range(0, 9)];
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 3))
         0: return $urandom_range(1, 1023);
         1: return $urandom_range(1024, 262143);
         2: return $urandom;
         default: return $urandom_range(140000, 170000);
      endcase
   endfunction

   // mostly angles near the targets, scaled to the gain so that deadband,
   // linear range and saturation are all reached; the rest is noise
   function automatic ankle_cmd_type random_cmd();
      ankle_cmd_type c;
      int pick;
      longint span;
      pick = $urandom_range(0, 9);
      c = {$urandom, $urandom};
      if (pick >= 2) begin
         if (pick >= 8) begin
            c.flex = corner_cmd();
            c.tilt = corner_cmd();
         end else begin
            c.flex = rand_pm(18000);
            c.tilt = rand_pm(18000);
         end
         if (pick != 9) begin
            span = (stim_gain == 0) ? 40000
                 : longint'(stim_mode ? 32600 : 11500) * 384 / stim_gain + 3;
            if (span > 40000) span = 40000;
            c.angle_one = clamp_ll(target_num(c, 1'b0) / CMD_SCALE + rand_pm(span),
                                   -32768, 32767);
            c.angle_two = clamp_ll(target_num(c, 1'b1) / CMD_SCALE + rand_pm(span),
                                   -32768, 32767);
         end
      end
      return c;
   endfunction

   // register copy, result check and expected-drive store, all on one edge
   always @(posedge clock) begin
      drive_set_type want, got;
      if (!reset) begin
         if (csr_wen) begin
            if (csr_addr == CSR_DRIVE_MODE) mode_now <= csr_wdata[0];
            else gain_now <= csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.drive_one  = rsp_tdata[FIELD_W-1:0];
            got.drive_two  = rsp_tdata[2*FIELD_W-1:FIELD_W];
            got.is_current = rsp_tuser;
            drives_seen++;
            if (pending_drives.size() == 0) begin
               $display("%0t: unexpected result transfer %p", $time, got);
               fault_count++;
            end else begin
               want = pending_drives.pop_front();
               if (got.drive_one !== want.drive_one) begin
                  $display("%0t: drive_one expected %0d, got %0d",
                           $time, want.drive_one, got.drive_one);
                  fault_count++;
               end
               if (got.drive_two !== want.drive_two) begin
                  $display("%0t: drive_two expected %0d, got %0d",
                           $time, want.drive_two, got.drive_two);
                  fault_count++;
               end
               if (got.is_current !== want.is_current) begin
                  $display("%0t: drive_is_current expected %0d, got %0d",
                           $time, want.is_current, got.is_current);
                  fault_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_drives.push_back(predict_drives(req_tdata, mode_now, gain_now));
            requests_sent++;
         end
      end
   end

   // receiver: short stalls often, a long one now and then to fill the pipe
   always @(posedge clock) begin
      if (!rx_idle_on) begin
         rsp_tready <= 1'b1;
      end else if (rx_hold != 0) begin
         rsp_tready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               rsp_tready <= 1'b0;
               rx_hold <= $urandom_range(10, 40);
            end
            1, 2, 3, 4: begin
               rsp_tready <= 1'b0;
               rx_hold <= $urandom_range(0, 5);
            end
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d drives pending", $time, pending_drives.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_cmd(ankle_cmd_type c);
      int gap;
      if (tx_idle_on && burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send4(int f, int t, int a1, int a2);
      ankle_cmd_type c;
      c.flex = f;
      c.tilt = t;
      c.angle_one = a1;
      c.angle_two = a2;
      send_cmd(c);
   endtask

   // stop sending and wait for every pending drive
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(logic cur, logic [GAIN_W-1:0] g);
      logic [GAIN_W-1:0] w;
      w = $urandom;
      w[0] = cur;
      csr_wen   <= 1'b1;
      csr_addr  <= CSR_DRIVE_MODE;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= CSR_GAIN;
      csr_wdata <= g;
      @(posedge clock);
      csr_wen   <= 1'b0;
      stim_mode = cur;
      stim_gain = g;
      settings_used++;
   endtask

   // reset settings: current drive, gain 153600
   task automatic test_command_corners();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send4(0, 0, 0, 0);
      send4(16384, 0, 250, 250);
      send4(32767, 0, 250, 260);
      send4(-32768, 0, 2400, 2390);
      send4(-16384, 0, 2400, 2400);
      send4(16385, -16385, 32767, -32768);
      send4(-16385, 16385, -32768, 32767);
      send4(0, 32767, 1285, 715);
      send4(0, -32768, 715, 1285);
      send4(-16384, 16384, 2400, 2400);
      send4(16384, -16384, 250, 250);
      send4(0, 0, 1013, 1008);
      send4(0, 0, 1012, 1007);
      send4(0, 0, 987, 992);
      send4(1, -1, 1000, 1000);
   endtask

   // unit and double gain at rest target so drive follows the angle error
   task automatic test_deadband_edges();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      settle();
      write_config(1'b0, GAIN_W'(256));
      send4(0, 0, 2525, 2523);
      send4(0, 0, 2524, 2522);
      send4(0, 0, -525, -523);
      send4(0, 0, 12500, 11455);
      send4(0, 0, 12501, 11456);
      settle();
      write_config(1'b1, GAIN_W'(512));
      send4(0, 0, 4750, 3400);
      send4(0, 0, 4749, 3399);
      send4(0, 0, 17300, 7520);
      send4(0, 0, 17301, 7521);
      send4(0, 0, -15300, -5520);
   endtask

   task automatic test_gain_extremes();
      logic [GAIN_W-1:0] gains[5] = '{0, 0, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}, 1};
      for (int i = 0; i < 5; i++) begin
         settle();
         write_config(i[0], gains[i]);
         tx_idle_on = $urandom_range(0, 1);
         rx_idle_on = $urandom_range(0, 1);
         repeat (50) send_cmd(random_cmd());
      end
   endtask

   task automatic test_random_settings();
      repeat (12) begin
         settle();
         write_config($urandom_range(0, 1), random_gain());
         tx_idle_on = $urandom_range(0, 2) != 0;
         rx_idle_on = $urandom_range(0, 2) != 0;
         repeat (75) send_cmd(random_cmd());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_command_corners();
      test_deadband_edges();
      test_gain_extremes();
      test_random_settings();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_drives.size() != 0) begin
         $display("%0t: %0d drives never arrived", $time, pending_drives.size());
         fault_count++;
      end
      $display("%0d commands and %0d drive transfers over %0d register settings",
               requests_sent, drives_seen, settings_used);
      $display("voltage and current drive, gains zero to full scale, clamps and deadbands");
      if (fault_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
